/* rtl/tgt_pkg.sv */
// Shared constants, codes and types for the touch gesture tracker.
package tgt_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int COORD_W       = 16;
    localparam int WIDTH_W       = 15;
    localparam int DIST_W        = 16;
    localparam int RELEASE_W     = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int HCOUNT_W      = $clog2(HISTORY_DEPTH + 1);

    // Event codes
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_DRAG  = 2'd1;
    localparam logic [1:0] EV_SWIPE = 2'd2;
    localparam logic [1:0] EV_STOP  = 2'd3;

    // Swipe direction codes
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_DISTANCE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COUNT  = 3'd4;

    // Reset values
    localparam logic [WIDTH_W-1:0]   DISPLAY_WIDTH_RST  = 15'd320;
    localparam logic [DIST_W-1:0]    SWIPE_DISTANCE_RST = 16'd5;
    localparam logic [RELEASE_W-1:0] RELEASE_COUNT_RST  = 4'd4;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

endpackage

/* rtl/tgt_if.sv */
// Valid/ready channel interfaces for touch samples and gesture events.
interface tgt_sample_if import tgt_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      touched;
    logic signed [COORD_W-1:0] raw_x;
    logic signed [COORD_W-1:0] raw_y;

    modport source (output valid, touched, raw_x, raw_y, input ready);
    modport sink   (input valid, touched, raw_x, raw_y, output ready);
endinterface

interface tgt_event_if import tgt_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [1:0]                event_res;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [1:0]                direction;

    modport source (output valid, event_res, pos_x, pos_y, direction, input ready);
    modport sink   (input valid, event_res, pos_x, pos_y, direction, output ready);
endinterface

/* rtl/touch_gesture_tracker_unit.sv */
// Touch gesture tracker: maps panel samples to start, drag, swipe and stop events.
//
// One touch sample is taken per clock when the pipeline can move. A sample
// is registered in the input stage, then combinational logic maps it to a view
// position, updates the three-point history and the no-touch counter, and loads
// the event register, from which the request is driven; sustained throughput is
// one sample per cycle while events are taken. A sample yields at most one
// event: touches always give start or drag, no-touch samples give a swipe,
// a stop once the release count is exceeded, or nothing. Configuration
// registers take effect on the next sample; write them only while idle.
module touch_gesture_tracker_unit import tgt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    tgt_sample_if.sink             sample,
    tgt_event_if.source            gesture
);

    // Configuration
    logic [WIDTH_W-1:0]   display_width_reg;
    logic [COORD_W-1:0]   offset_x_reg;
    logic [COORD_W-1:0]   offset_y_reg;
    logic [DIST_W-1:0]    swipe_distance_reg;
    logic [RELEASE_W-1:0] release_count_reg;

    // Input stage
    logic               s1_valid_reg;
    logic               s1_touched_reg;
    logic [COORD_W-1:0] s1_raw_x_reg;
    logic [COORD_W-1:0] s1_raw_y_reg;

    // Tracker state
    point_t               hist_reg [HISTORY_DEPTH];
    point_t               hist_next [HISTORY_DEPTH];
    logic [HCOUNT_W-1:0]  hcount_reg, hcount_next;
    logic                 active_reg, active_next;
    logic [RELEASE_W-1:0] idle_reg, idle_next;

    // Event register
    logic               out_valid_reg;
    logic [1:0]         out_event_reg, out_event_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    logic [1:0]         out_dir_reg, out_dir_next;
    logic               emit;

    logic advance;

    logic [COORD_W-1:0]   view_x, view_y;
    logic                 step0_far, step1_far;
    logic [COORD_W-1:0]   wdx, wdy;
    logic [COORD_W:0]     mag_dx, mag_dy;
    logic [RELEASE_W:0]   idle_inc;
    logic [1:0]           swipe_dir;

    // Exact Manhattan distance between two points, compared to the threshold
    function automatic logic step_exceeds(point_t a, point_t b, logic [DIST_W-1:0] thr);
        logic signed [COORD_W:0] dx, dy;
        logic        [COORD_W:0] ax, ay;
        logic        [COORD_W+1:0] sum;
        dx  = $signed({b.x[COORD_W-1], b.x}) - $signed({a.x[COORD_W-1], a.x});
        dy  = $signed({b.y[COORD_W-1], b.y}) - $signed({a.y[COORD_W-1], a.y});
        ax  = dx[COORD_W] ? (~dx + 1'b1) : dx;
        ay  = dy[COORD_W] ? (~dy + 1'b1) : dy;
        sum = {1'b0, ax} + {1'b0, ay};
        return sum > {2'b00, thr};
    endfunction

    assign advance       = !out_valid_reg || gesture.ready;
    assign sample.ready  = !s1_valid_reg || advance;

    assign gesture.valid     = out_valid_reg;
    assign gesture.event_res = out_event_reg;
    assign gesture.pos_x     = out_x_reg;
    assign gesture.pos_y     = out_y_reg;
    assign gesture.direction = out_dir_reg;

    always_comb
    begin
        view_x = {1'b0, display_width_reg} - s1_raw_x_reg + offset_x_reg;
        view_y = s1_raw_y_reg + offset_y_reg;

        step0_far = step_exceeds(hist_reg[0], hist_reg[1], swipe_distance_reg);
        step1_far = step_exceeds(hist_reg[1], hist_reg[2], swipe_distance_reg);

        // Direction uses the last step wrapped to 16 bits
        wdx    = hist_reg[2].x - hist_reg[1].x;
        wdy    = hist_reg[2].y - hist_reg[1].y;
        mag_dx = wdx[COORD_W-1] ? (~{1'b1, wdx} + 1'b1) : {1'b0, wdx};
        mag_dy = wdy[COORD_W-1] ? (~{1'b1, wdy} + 1'b1) : {1'b0, wdy};
        if (mag_dx > mag_dy)
            swipe_dir = (!wdx[COORD_W-1] && (wdx != '0)) ? DIR_RIGHT : DIR_LEFT;
        else
            swipe_dir = (!wdy[COORD_W-1] && (wdy != '0)) ? DIR_DOWN : DIR_UP;

        idle_inc = {1'b0, idle_reg} + 1'b1;

        hist_next      = hist_reg;
        hcount_next    = hcount_reg;
        active_next    = active_reg;
        idle_next      = idle_reg;
        emit           = 1'b0;
        out_event_next = EV_START;
        out_x_next     = '0;
        out_y_next     = '0;
        out_dir_next   = DIR_RIGHT;

        if (s1_touched_reg)
        begin
            idle_next = '0;
            if (hcount_reg >= HCOUNT_W'(HISTORY_DEPTH))
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    hist_next[i] = hist_reg[i + 1];
                hist_next[HISTORY_DEPTH-1] = '{y: view_y, x: view_x};
                hcount_next = HCOUNT_W'(HISTORY_DEPTH);
            end
            else
            begin
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    if (hcount_reg == HCOUNT_W'(i))
                        hist_next[i] = '{y: view_y, x: view_x};
                hcount_next = hcount_reg + 1'b1;
            end
            emit           = 1'b1;
            out_event_next = active_reg ? EV_DRAG : EV_START;
            active_next    = 1'b1;
            out_x_next     = view_x;
            out_y_next     = view_y;
        end
        else if (active_reg)
        begin
            if (hcount_reg >= HCOUNT_W'(HISTORY_DEPTH) && step0_far && step1_far)
            begin
                emit           = 1'b1;
                out_event_next = EV_SWIPE;
                out_dir_next   = swipe_dir;
                active_next    = 1'b0;
                hcount_next    = '0;
                for (int i = 0; i < HISTORY_DEPTH; i++)
                    hist_next[i] = '0;
            end
            else
            begin
                // Counter saturates; stop compares the unsaturated increment
                idle_next = idle_inc[RELEASE_W] ? '1 : idle_inc[RELEASE_W-1:0];
                if (idle_inc > {1'b0, release_count_reg})
                begin
                    emit           = 1'b1;
                    out_event_next = EV_STOP;
                    active_next    = 1'b0;
                    hcount_next    = '0;
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                        hist_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_width_reg  <= DISPLAY_WIDTH_RST;
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
            swipe_distance_reg <= SWIPE_DISTANCE_RST;
            release_count_reg  <= RELEASE_COUNT_RST;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            hcount_reg         <= '0;
            active_reg         <= 1'b0;
            idle_reg           <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_DISPLAY_WIDTH:  display_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                    REG_OFFSET_X:       offset_x_reg       <= cfg_wdata[COORD_W-1:0];
                    REG_OFFSET_Y:       offset_y_reg       <= cfg_wdata[COORD_W-1:0];
                    REG_SWIPE_DISTANCE: swipe_distance_reg <= cfg_wdata[DIST_W-1:0];
                    REG_RELEASE_COUNT:  release_count_reg  <= cfg_wdata[RELEASE_W-1:0];
                    default: ;
                endcase
            end

            if (sample.ready)
                s1_valid_reg <= sample.valid;

            if (advance)
            begin
                out_valid_reg <= s1_valid_reg && emit;
                if (s1_valid_reg)
                begin
                    hist_reg   <= hist_next;
                    hcount_reg <= hcount_next;
                    active_reg <= active_next;
                    idle_reg   <= idle_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_touched_reg <= sample.touched;
            s1_raw_x_reg   <= sample.raw_x;
            s1_raw_y_reg   <= sample.raw_y;
        end
        if (advance && s1_valid_reg && emit)
        begin
            out_event_reg <= out_event_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_dir_reg   <= out_dir_next;
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench for the touch gesture tracker: random gesture streams checked against a local predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tgt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic        touched;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
    } sample_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  dir;
    } gesture_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    tgt_sample_if sample_ch();
    tgt_event_if  event_ch();

    touch_gesture_tracker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch),
        .gesture   (event_ch)
    );

    // predictor state and its copy of the registers
    logic [WIDTH_W-1:0]   disp_width;
    logic [15:0]          off_x;
    logic [15:0]          off_y;
    logic [DIST_W-1:0]    swipe_dist;
    logic [RELEASE_W-1:0] release_cnt;
    point_t               hist [HISTORY_DEPTH];
    int                   hist_cnt;
    bit                   gesture_on;
    int                   idle_run;

    sample_t  pending [$];
    gesture_t expected [$];

    int  mismatches;
    int  samples_taken;
    int  cycles;
    int  events_seen [4];
    bit  idle_on;
    int  src_gap, src_calm, snk_gap, snk_calm;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d events outstanding", cycles, expected.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int mag16(logic [15:0] v);
        int s;
        s = int'($signed(v));
        return (s < 0) ? -s : s;
    endfunction

    // exact Manhattan length, no wrap
    function automatic int step_len(point_t a, point_t b);
        int ax, ay, bx, by, dx, dy;
        ax = int'($signed(a.x));
        ay = int'($signed(a.y));
        bx = int'($signed(b.x));
        by = int'($signed(b.y));
        dx = bx - ax;
        dy = by - ay;
        return ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
    endfunction

    task automatic clear_hist();
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist[i] = '0;
        hist_cnt = 0;
    endtask

    task automatic reset_tracker();
        disp_width  = DISPLAY_WIDTH_RST;
        off_x       = '0;
        off_y       = '0;
        swipe_dist  = SWIPE_DISTANCE_RST;
        release_cnt = RELEASE_COUNT_RST;
        clear_hist();
        gesture_on  = 1'b0;
        idle_run    = 0;
    endtask

    task automatic predict_gesture(logic touched, logic [15:0] rx, logic [15:0] ry);
        gesture_t    g;
        point_t      p;
        int          next_idle;
        logic [15:0] dx16, dy16;
        g = '{kind: EV_START, x: 16'd0, y: 16'd0, dir: DIR_RIGHT};
        if (touched)
        begin
            p.x = {1'b0, disp_width} - rx + off_x;
            p.y = ry + off_y;
            idle_run = 0;
            if (hist_cnt >= HISTORY_DEPTH)
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    hist[i] = hist[i + 1];
                hist_cnt = HISTORY_DEPTH - 1;
            end
            hist[hist_cnt] = p;
            hist_cnt++;
            g.kind = gesture_on ? EV_DRAG : EV_START;
            g.x = p.x;
            g.y = p.y;
            gesture_on = 1'b1;
            expected.insert(expected.size(), g);
        end
        else if (gesture_on)
        begin
            if (hist_cnt >= HISTORY_DEPTH &&
                step_len(hist[0], hist[1]) > int'(swipe_dist) &&
                step_len(hist[1], hist[2]) > int'(swipe_dist))
            begin
                // axis choice uses the wrapped last step
                dx16 = hist[2].x - hist[1].x;
                dy16 = hist[2].y - hist[1].y;
                if (mag16(dx16) > mag16(dy16))
                    g.dir = ($signed(dx16) > 0) ? DIR_RIGHT : DIR_LEFT;
                else
                    g.dir = ($signed(dy16) > 0) ? DIR_DOWN : DIR_UP;
                g.kind = EV_SWIPE;
                gesture_on = 1'b0;
                clear_hist();
                expected.insert(expected.size(), g);
            end
            else
            begin
                next_idle = idle_run + 1;
                idle_run = (next_idle > 15) ? 15 : next_idle;
                if (next_idle > int'(release_cnt))
                begin
                    gesture_on = 1'b0;
                    clear_hist();
                    g.kind = EV_STOP;
                    expected.insert(expected.size(), g);
                end
            end
        end
    endtask

    // random idle bursts, with calm stretches in between
    function automatic bit take_gap(inout int gap, inout int calm);
        if (gap > 0)
        begin
            gap--;
            return 1'b1;
        end
        if (!idle_on)
            return 1'b0;
        if (calm > 0)
        begin
            calm--;
            return 1'b0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            if ($urandom_range(0, 1))
            begin
                gap = $urandom_range(1, 19) - 1;
                return 1'b1;
            end
            calm = $urandom_range(20, 60);
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        sample_t s;
        if (!rst_n)
        begin
            sample_ch.valid   <= 1'b0;
            sample_ch.touched <= 1'b0;
            sample_ch.raw_x   <= '0;
            sample_ch.raw_y   <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predict_gesture(sample_ch.touched, sample_ch.raw_x, sample_ch.raw_y);
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (take_gap(src_gap, src_calm) || pending.size() == 0)
                    sample_ch.valid <= 1'b0;
                else
                begin
                    s = pending[0];
                    pending.delete(0);
                    sample_ch.valid   <= 1'b1;
                    sample_ch.touched <= s.touched;
                    sample_ch.raw_x   <= s.raw_x;
                    sample_ch.raw_y   <= s.raw_y;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_events
        gesture_t want;
        if (!rst_n)
            event_ch.ready <= 1'b0;
        else
        begin
            if (event_ch.valid && event_ch.ready)
            begin
                events_seen[event_ch.event_res]++;
                if (expected.size() == 0)
                    report_mismatch("request with nothing expected, event",
                                    16'(event_ch.event_res), 16'd0);
                else
                begin
                    want = expected[0];
                    expected.delete(0);
                    if (event_ch.event_res !== want.kind)
                        report_mismatch("event_res", 16'(event_ch.event_res), 16'(want.kind));
                    if (event_ch.pos_x !== want.x)
                        report_mismatch("pos_x", event_ch.pos_x, want.x);
                    if (event_ch.pos_y !== want.y)
                        report_mismatch("pos_y", event_ch.pos_y, want.y);
                    if (event_ch.direction !== want.dir)
                        report_mismatch("direction", 16'(event_ch.direction), 16'(want.dir));
                end
            end
            event_ch.ready <= !take_gap(snk_gap, snk_calm);
        end
    end

    task automatic queue_sample(logic touched, logic [15:0] rx, logic [15:0] ry);
        sample_t s;
        s.touched = touched;
        s.raw_x   = rx;
        s.raw_y   = ry;
        pending.insert(pending.size(), s);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DISPLAY_WIDTH:  disp_width  = data[WIDTH_W-1:0];
            REG_OFFSET_X:       off_x       = data;
            REG_OFFSET_Y:       off_y       = data;
            REG_SWIPE_DISTANCE: swipe_dist  = data;
            REG_RELEASE_COUNT:  release_cnt = data[RELEASE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic apply_settings(logic [15:0] dw, logic [15:0] ox, logic [15:0] oy,
                                  logic [15:0] sd, logic [15:0] rc);
        write_reg(REG_DISPLAY_WIDTH, dw);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_SWIPE_DISTANCE, sd);
        write_reg(REG_RELEASE_COUNT, rc);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until the block has gone quiet
    task automatic drain();
        do
            @(negedge clk);
        while (pending.size() != 0 || sample_ch.valid || expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int step_delta();
        int d;
        int lim;
        lim = int'(swipe_dist);
        case ($urandom_range(0, 3))
            0:       d = $urandom_range(0, lim / 2);
            1:       d = lim + $urandom_range(1, 40);
            2:       d = $urandom_range(0, 65535);
            default: d = 0;
        endcase
        return $urandom_range(0, 1) ? -d : d;
    endfunction

    // mostly touch strokes followed by a run of releases, some pure noise
    task automatic make_gestures(int count);
        int          made;
        int          tail;
        logic [15:0] px, py;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_sample(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                made++;
            end
            else
            begin
                px = 16'($urandom);
                py = 16'($urandom);
                repeat ($urandom_range(1, 6))
                begin
                    queue_sample(1'b1, px, py);
                    made++;
                    px = px + 16'(step_delta());
                    py = py + 16'(step_delta());
                end
                tail = $urandom_range(0, int'(release_cnt) + 3);
                repeat (tail)
                begin
                    queue_sample(1'b0, 16'($urandom), 16'($urandom));
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.touched = 1'b0;
        sample_ch.raw_x = '0;
        sample_ch.raw_y = '0;
        event_ch.ready = 1'b0;
        idle_on = 1'b1;
        reset_tracker();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, history roll-over, stop, swipes right, up and down
        queue_sample(1'b0, 16'($urandom), 16'($urandom));  // no touch while idle
        queue_sample(1'b1, 16'h8000, 16'h7FFF);
        queue_sample(1'b1, 16'h7FFF, 16'h8000);
        queue_sample(1'b1, 16'h0000, 16'h0000);
        queue_sample(1'b1, 16'hFFFF, 16'hFFFF);          // oldest point dropped
        repeat (5) queue_sample(1'b0, 16'($urandom), 16'($urandom)); // ends in stop
        queue_sample(1'b1, 16'd100, 16'd100);
        queue_sample(1'b1, 16'd80, 16'd100);
        queue_sample(1'b1, 16'd60, 16'd100);
        queue_sample(1'b0, 16'd0, 16'd0);                // swipe right
        queue_sample(1'b0, 16'd0, 16'd0);
        queue_sample(1'b1, 16'd0, 16'd100);
        queue_sample(1'b1, 16'd0, 16'd90);
        queue_sample(1'b1, 16'd0, 16'd80);
        queue_sample(1'b0, 16'd0, 16'd0);                // swipe up
        queue_sample(1'b1, 16'd0, 16'd0);
        queue_sample(1'b1, 16'd10, 16'd10);
        queue_sample(1'b1, 16'd20, 16'd20);
        queue_sample(1'b0, 16'd0, 16'd0);                // tie goes to y: down
        queue_sample(1'b1, 16'd0, 16'd0);
        queue_sample(1'b1, -16'sd20000, 16'd0);
        queue_sample(1'b1, 16'sd20000, 16'd0);
        queue_sample(1'b0, 16'd0, 16'd0);                // wrapped step flips to right
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph != NUM_PHASES - 1);
            case (ph)
                0: apply_settings(16'hFFFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
                1: apply_settings(16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd15);
                default:
                begin
                    if (ph == 2)
                        write_reg(REG_UNUSED, 16'($urandom));
                    apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom_range(0, 60)), 16'($urandom_range(0, 15)));
                end
            endcase
            make_gestures(200);
            drain();
        end

        $display("Run covered %0d samples over %0d register settings plus reset values",
                 samples_taken, NUM_PHASES);
        $display("Events checked: start %0d, drag %0d, swipe %0d, stop %0d; mismatches %0d",
                 events_seen[EV_START], events_seen[EV_DRAG], events_seen[EV_SWIPE],
                 events_seen[EV_STOP], mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
